### rtl/pfli_pkg.sv
`timescale 1ns / 1ps

package pfli_pkg;

   localparam int PFLI_FRAME_BYTES = 32;
   localparam int PFLI_NUM_LIMITS  = 6;
   localparam int PFLI_LIMIT_W     = 16;
   localparam int PFLI_LEVEL_W     = 3;
   localparam int PFLI_PM_W        = 16;
   localparam int PFLI_BYTE_W      = 8;
   localparam int PFLI_IDX_W       = $clog2(PFLI_NUM_LIMITS);
   localparam int PFLI_ADDR_W      = PFLI_IDX_W + 2;
   localparam int PFLI_CSR_W       = 32;
   localparam int PFLI_RSP_W       = 24;

   localparam logic [PFLI_BYTE_W-1:0] PFLI_START_0 = 8'h42;
   localparam logic [PFLI_BYTE_W-1:0] PFLI_START_1 = 8'h4d;
   localparam int PFLI_POS_HIGH = 12;
   localparam int PFLI_POS_LOW  = 13;

   localparam logic [PFLI_LEVEL_W-1:0] PFLI_LEVEL_GOOD = 3'd0;
   localparam logic [PFLI_LEVEL_W-1:0] PFLI_LEVEL_MOD  = 3'd1;
   localparam logic [PFLI_LEVEL_W-1:0] PFLI_LEVEL_SENS = 3'd2;
   localparam logic [PFLI_LEVEL_W-1:0] PFLI_LEVEL_TOP  = 3'd6;

   localparam logic [PFLI_LIMIT_W-1:0] PFLI_LIMIT_RESET [PFLI_NUM_LIMITS] =
      '{16'd12, 16'd35, 16'd55, 16'd150, 16'd250, 16'd500};

   typedef logic [PFLI_NUM_LIMITS-1:0][PFLI_LIMIT_W-1:0] limits_type;

   typedef struct packed {
      logic                 done;
      logic [PFLI_PM_W-1:0] pm;
      logic                 header_bad;
      logic                 lit;
   } frame_type;

   typedef struct packed {
      logic [PFLI_LEVEL_W-1:0] level;
      logic                    red;
      logic                    green;
      logic                    blue;
   } class_type;

   // red, green, blue for a level; purple above the sensitive band
   function automatic logic [2:0] pfli_color(input logic [PFLI_LEVEL_W-1:0] level);
      logic [2:0] rgb;
      case (level)
         PFLI_LEVEL_GOOD: rgb = 3'b010;
         PFLI_LEVEL_MOD:  rgb = 3'b001;
         PFLI_LEVEL_SENS: rgb = 3'b100;
         default:         rgb = 3'b101;
      endcase
      return rgb;
   endfunction

endpackage

### rtl/pfli_csr.sv
`timescale 1ns / 1ps

module pfli_csr
   import pfli_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [PFLI_ADDR_W-1:0] paddr,
   input  logic [PFLI_CSR_W-1:0]  pwdata,
   output logic [PFLI_CSR_W-1:0]  prdata,
   output limits_type             limits
);

   limits_type            limits_ff;
   limits_type            limits_in;
   logic [PFLI_IDX_W-1:0] idx;
   logic                  idx_ok;

   assign idx    = paddr[PFLI_ADDR_W-1:2];
   assign idx_ok = (32'(idx) < PFLI_NUM_LIMITS);

   always_comb begin
      limits_in = limits_ff;
      if (psel && penable && pwrite && idx_ok) begin
         limits_in[idx] = pwdata[PFLI_LIMIT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PFLI_NUM_LIMITS; k++) begin
            limits_ff[k] <= PFLI_LIMIT_RESET[k];
         end
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign prdata = idx_ok ? {{(PFLI_CSR_W-PFLI_LIMIT_W){1'b0}}, limits_ff[idx]} : '0;
   assign limits = limits_ff;

endmodule

### rtl/pfli_parser.sv
`timescale 1ns / 1ps

module pfli_parser
   import pfli_pkg::*;
#(
   parameter int FRAME_BYTES = PFLI_FRAME_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [PFLI_BYTE_W-1:0] rx_byte,
   output frame_type              frame
);

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_HIGH = POS_W'(PFLI_POS_HIGH);
   localparam logic [POS_W-1:0] POS_LOW  = POS_W'(PFLI_POS_LOW);

   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [PFLI_BYTE_W-1:0] high_ff, high_in;
   logic [PFLI_BYTE_W-1:0] low_ff, low_in;
   logic                   bad_ff, bad_in;
   logic                   lit_ff, lit_in;
   logic                   last;

   assign last = (pos_ff == POS_LAST);

   always_comb begin
      pos_in  = pos_ff;
      high_in = high_ff;
      low_in  = low_ff;
      bad_in  = bad_ff;
      lit_in  = lit_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            bad_in = (rx_byte != PFLI_START_0);
         end else if (pos_ff == POS_W'(1)) begin
            bad_in = bad_ff | (rx_byte != PFLI_START_1);
         end else if (pos_ff == POS_HIGH) begin
            high_in = rx_byte;
         end else if (pos_ff == POS_LOW) begin
            low_in = rx_byte;
         end
         if (last) begin
            pos_in = '0;
            lit_in = ~lit_ff;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         high_ff <= '0;
         low_ff  <= '0;
         bad_ff  <= 1'b0;
         lit_ff  <= 1'b1;
      end else begin
         pos_ff  <= pos_in;
         high_ff <= high_in;
         low_ff  <= low_in;
         bad_ff  <= bad_in;
         lit_ff  <= lit_in;
      end
   end

   // low byte may be the frame's last byte in the shortest frame
   assign frame.done       = last;
   assign frame.pm         = {high_ff, (pos_ff == POS_LOW) ? rx_byte : low_ff};
   assign frame.header_bad = bad_ff;
   assign frame.lit        = lit_ff;

endmodule

### rtl/pfli_classifier.sv
`timescale 1ns / 1ps

module pfli_classifier
   import pfli_pkg::*;
(
   input  logic [PFLI_PM_W-1:0] pm,
   input  logic                 lit,
   input  limits_type           limits,
   output class_type            result
);

   logic [PFLI_LEVEL_W-1:0] level;
   logic [2:0]              rgb;

   // first limit above the value wins
   always_comb begin
      level = PFLI_LEVEL_TOP;
      for (int k = PFLI_NUM_LIMITS - 1; k >= 0; k--) begin
         if (pm < limits[k]) begin
            level = PFLI_LEVEL_W'(k);
         end
      end
   end

   assign rgb          = lit ? pfli_color(level) : 3'b000;
   assign result.level = level;
   assign result.red   = rgb[2];
   assign result.green = rgb[1];
   assign result.blue  = rgb[0];

endmodule

### rtl/particle_frame_level_indicator_top.sv
`timescale 1ns / 1ps
// channel   dir  transfer
// req_      in   one sensor byte per transfer
// rsp_      out  one result per completed frame
// csr_      in   six 16-bit limit registers at 4*i
//
// one byte per cycle; the result goes out the cycle after the last byte
// the single output register sets the rate: req_tready drops only while a
// result waits and rsp_tready is low
// reset clears the byte counter, captures and output valid, limits to defaults
// the first frame after reset is shown lit

module particle_frame_level_indicator_top
   import pfli_pkg::*;
#(
   parameter int FRAME_BYTES = PFLI_FRAME_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [PFLI_BYTE_W-1:0] req_tdata,   // rx_byte
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // pm_value[15:0] level[18:16] led_red[19] led_green[20] led_blue[21]
   // header_error[22] zero[23]
   output logic [PFLI_RSP_W-1:0]  rsp_tdata,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [PFLI_ADDR_W-1:0] csr_paddr,
   input  logic [PFLI_CSR_W-1:0]  csr_pwdata,
   output logic [PFLI_CSR_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   limits_type                limits;
   frame_type                 frame;
   class_type                 cls;
   logic                      req_accept;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PFLI_RSP_W-1:0]     rsp_data_ff, rsp_data_in;

   assign csr_pready = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   pfli_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .limits  (limits)
   );

   pfli_parser #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_tdata),
      .frame   (frame)
   );

   pfli_classifier u_classifier (
      .pm     (frame.pm),
      .lit    (frame.lit),
      .limits (limits),
      .result (cls)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept && frame.done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, frame.header_bad, cls.blue, cls.green, cls.red,
                         cls.level, frame.pm};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_frame_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && frame.done |=> rsp_tvalid)
      else $error("frame end without result");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[18:16] <= PFLI_LEVEL_TOP)
      else $error("level out of range");

   a_green_only_good: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20] |-> rsp_tdata[18:16] == PFLI_LEVEL_GOOD
                                      && !rsp_tdata[19] && !rsp_tdata[21])
      else $error("green lit outside good level");

   a_blink_toggles: assert property (@(posedge clock) disable iff (reset)
      req_accept && frame.done |=> frame.lit != $past(frame.lit))
      else $error("blink phase did not alternate");
`endif

endmodule
